// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/ppd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppd_pkg;

   // Line buffer geometry
   localparam int MAX_ROW_WIDTH = 1024;
   localparam int COL_W         = $clog2(MAX_ROW_WIDTH + 1);
   localparam int ADDR_W        = $clog2(MAX_ROW_WIDTH);
   localparam int ROW_WIDTH_W   = 11;
   localparam int CMP_W         = (COL_W > ROW_WIDTH_W) ? COL_W : ROW_WIDTH_W;

   // Sample and register file widths
   localparam int DATA_W     = 64;
   localparam int SIZE_W     = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes (word address bit 2)
   localparam logic REG_ROW_WIDTH = 1'b0;
   localparam logic REG_ELT_SIZE  = 1'b1;

   // Element size codes
   localparam logic [SIZE_W-1:0] SIZE_1B = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_2B = 2'd1;
   localparam logic [SIZE_W-1:0] SIZE_4B = 2'd2;
   localparam logic [SIZE_W-1:0] SIZE_8B = 2'd3;

   typedef struct packed {
      logic [ROW_WIDTH_W-1:0] row_width;
      logic [SIZE_W-1:0]      elt_size_code;
   } cfg_type;

   // Position of the item entering the line buffer read
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              col_zero;
      logic              first_row;
      logic              in_store;
   } pos_type;

   typedef struct packed {
      logic s1_busy;
      logic s1_adv;
   } stat_type;

   function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] code);
      logic [DATA_W-1:0] m;
      unique case (code)
         SIZE_1B: m = 64'h0000_0000_0000_00FF;
         SIZE_2B: m = 64'h0000_0000_0000_FFFF;
         SIZE_4B: m = 64'h0000_0000_FFFF_FFFF;
         SIZE_8B: m = 64'hFFFF_FFFF_FFFF_FFFF;
         default: m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ppd_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ppd_req_if import ppd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] residual;
   logic              last_in_buffer;

   modport source (output valid, residual, last_in_buffer, input ready);
   modport sink   (input valid, residual, last_in_buffer, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ppd_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ppd_rsp_if import ppd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] sample;
   logic              last_out;

   modport source (output valid, sample, last_out, input ready);
   modport sink   (input valid, sample, last_out, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ppd_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module ppd_csr import ppd_pkg::*; (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    psel,
   input  wire                    penable,
   input  wire                    pwrite,
   input  wire [CSR_ADDR_W-1:0]   paddr,
   input  wire [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_ROW_WIDTH: cfg_in.row_width     = pwdata[ROW_WIDTH_W-1:0];
            REG_ELT_SIZE:  cfg_in.elt_size_code = pwdata[SIZE_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (paddr[2])
         REG_ROW_WIDTH: prdata = CSR_DATA_W'(cfg_ff.row_width);
         REG_ELT_SIZE:  prdata = CSR_DATA_W'(cfg_ff.elt_size_code);
         default:       prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ppd_position.sv
`timescale 1ns / 1ps
`default_nettype none

module ppd_position import ppd_pkg::*; (
   input  wire      clock,
   input  wire      reset,
   input  cfg_type  cfg,
   input  wire      accept,
   input  wire      last,
   output pos_type  pos
);

   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic             first_ff;
   logic             first_in;

   logic [CMP_W-1:0] rw_ext;
   logic [CMP_W-1:0] eff_w;
   logic             wrap_pre;
   logic             wrap_post;
   logic [COL_W-1:0] col_cur;
   logic             first_cur;
   logic             in_store;
   logic [COL_W-1:0] col_inc;

   // Clamp the row width to the line buffer depth
   always_comb begin
      rw_ext = CMP_W'(cfg.row_width);
      eff_w  = (rw_ext > CMP_W'(MAX_ROW_WIDTH)) ? CMP_W'(MAX_ROW_WIDTH) : rw_ext;
   end

   // End the row early if the width shrank under the current column
   assign wrap_pre  = (eff_w != '0) && (CMP_W'(col_ff) >= eff_w);
   assign col_cur   = wrap_pre ? '0 : col_ff;
   assign first_cur = first_ff && !wrap_pre;
   assign in_store  = col_cur < COL_W'(MAX_ROW_WIDTH);

   // Advance, saturating at the buffer depth in single-row mode
   assign col_inc   = in_store ? COL_W'(col_cur + 1'b1) : col_cur;
   assign wrap_post = (eff_w != '0) && (CMP_W'(col_inc) >= eff_w);

   always_comb begin
      col_in   = col_ff;
      first_in = first_ff;
      if (accept) begin
         if (last) begin
            col_in   = '0;
            first_in = 1'b1;
         end else if (wrap_post) begin
            col_in   = '0;
            first_in = 1'b0;
         end else begin
            col_in   = col_inc;
            first_in = first_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         first_ff <= 1'b1;
      end else begin
         col_ff   <= col_in;
         first_ff <= first_in;
      end
   end

   always_comb begin
      pos.addr      = col_cur[ADDR_W-1:0];
      pos.col_zero  = (col_cur == '0);
      pos.first_row = first_cur;
      pos.in_store  = in_store;
   end

endmodule

`default_nettype wire

// File: hw/rtl/ppd_recon.sv
`timescale 1ns / 1ps
`default_nettype none

module ppd_recon import ppd_pkg::*; (
   input  wire                clock,
   input  wire                reset,
   input  cfg_type            cfg,
   input  wire                accept,
   input  wire [DATA_W-1:0]   residual,
   input  wire                last,
   input  pos_type            pos,
   output logic               in_ready,
   output stat_type           stat,
   ppd_rsp_if.source          rsp
);

   logic [DATA_W-1:0] line_store [MAX_ROW_WIDTH];

   // Reconstruct stage
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [DATA_W-1:0] s1_res_ff;
   logic              s1_last_ff;
   pos_type           s1_pos_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              fwd_hit_ff;
   logic [DATA_W-1:0] fwd_data_ff;
   logic [DATA_W-1:0] left_ff;
   logic [DATA_W-1:0] upleft_ff;

   // Output register
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [DATA_W-1:0] out_sample_ff;
   logic              out_last_ff;

   logic              s1_adv;
   logic [DATA_W-1:0] mask;
   logic [DATA_W-1:0] n_raw;
   logic [DATA_W-1:0] n_val;
   logic [DATA_W-1:0] nw_val;
   logic [DATA_W-1:0] w_val;
   logic [DATA_W-1:0] x_val;
   logic              wr_en;
   logic              fwd_hit;

   assign s1_adv   = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign in_ready = !s1_valid_ff || s1_adv;
   assign mask     = size_mask(cfg.elt_size_code);

   // Take the row above from the write just made when it hit the same entry
   assign n_raw  = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign n_val  = (!s1_pos_ff.first_row && s1_pos_ff.in_store) ? n_raw : '0;
   assign nw_val = (s1_pos_ff.first_row || s1_pos_ff.col_zero) ? '0 : upleft_ff;
   assign w_val  = s1_pos_ff.col_zero ? '0 : left_ff;
   assign x_val  = (s1_res_ff + w_val + n_val - nw_val) & mask;

   assign wr_en   = s1_adv && s1_pos_ff.in_store;
   assign fwd_hit = wr_en && (s1_pos_ff.addr == pos.addr);

   // Line store: read on accept, write back on stage advance
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_store[s1_pos_ff.addr] <= x_val;
      end
      if (accept) begin
         rd_data_ff <= line_store[pos.addr];
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff   <= residual;
         s1_last_ff  <= last;
         s1_pos_ff   <= pos;
         fwd_hit_ff  <= fwd_hit;
         fwd_data_ff <= x_val;
      end
      if (s1_adv) begin
         left_ff       <= x_val;
         upleft_ff     <= n_val;
         out_sample_ff <= x_val;
         out_last_ff   <= s1_last_ff;
      end
   end

   // Valid flags
   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_adv ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.sample   = out_sample_ff;
   assign rsp.last_out = out_last_ff;

   assign stat.s1_busy = s1_valid_ff;
   assign stat.s1_adv  = s1_adv;

endmodule

`default_nettype wire

// File: hw/rtl/planar_predictor_decoder_top.sv
// Planar predictor decoder: rebuilds each sample as residual + W + N - NW, wrapped to the
// element size, from residuals streamed in raster order. It takes one transaction per
// clock cycle unless a stalled output holds the stage: the line store is read at the
// accepting edge, and the add lands in the output register when the stage advances. The
// rate is set by the line store, one read and one write per cycle, with the just-written
// sample forwarded when a one-sample row reads back the entry it wrote. A stalled output
// holds the stage and drops ready in the same cycle. The line store has no clearing pass.
// Write row_width and elt_size_code only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module planar_predictor_decoder_top import ppd_pkg::*; (
   input  wire                    clock,
   input  wire                    reset,
   ppd_req_if.sink                req_chan,
   ppd_rsp_if.source              rsp_chan,
   input  wire                    csr_psel,
   input  wire                    csr_penable,
   input  wire                    csr_pwrite,
   input  wire [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   cfg_type  cfg;
   pos_type  pos;
   stat_type stat;
   logic     in_ready;
   logic     req_accept;
   logic     last_accept;
   logic     pos_at_start;

   assign req_chan.ready = in_ready;
   assign req_accept     = req_chan.valid && in_ready;

   // Register file
   ppd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Column and row tracking
   ppd_position u_position (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .accept (req_accept),
      .last   (req_chan.last_in_buffer),
      .pos    (pos)
   );

   // Line store and reconstruction
   ppd_recon u_recon (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .accept   (req_accept),
      .residual (req_chan.residual),
      .last     (req_chan.last_in_buffer),
      .pos      (pos),
      .in_ready (in_ready),
      .stat     (stat),
      .rsp      (rsp_chan)
   );

   assign last_accept  = req_accept && req_chan.last_in_buffer;
   assign pos_at_start = pos.col_zero && pos.first_row;

   // Hold off new transactions while the stage is stalled
   `ASSERT_IMPLIES(a_stall_blocks_input, clock, reset, (stat.s1_busy && !stat.s1_adv), !in_ready)
   // A result appears only after the stage advanced
   `ASSERT_IMPLIES(a_out_from_stage, clock, reset, $rose(rsp_chan.valid), $past(stat.s1_adv))
   // A flagged last transaction returns the position to the buffer start
   `ASSERT_NEXT(a_last_resets_pos, clock, reset, last_accept, pos_at_start)

endmodule

`default_nettype wire

// File: bench/planar_predictor_decoder_top_tb.sv
`timescale 1ns / 1ps

module planar_predictor_decoder_top_tb;
   import ppd_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_ROW_WIDTH = {REG_ROW_WIDTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_ELT_SIZE  = {REG_ELT_SIZE, 2'b00};

   typedef struct {
      logic [DATA_W-1:0] residual;
      logic              last;
      bit                drain;
   } residual_type;

   typedef struct packed {
      logic [DATA_W-1:0] sample;
      logic              last;
   } sample_type;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Local copies of the channel inputs, known from time zero
   logic              residual_valid = 1'b0;
   logic [DATA_W-1:0] residual_data  = '0;
   logic              residual_last  = 1'b0;
   logic              sample_ready   = 1'b0;

   ppd_req_if req_if ();
   ppd_rsp_if rsp_if ();

   assign req_if.valid          = residual_valid;
   assign req_if.residual       = residual_data;
   assign req_if.last_in_buffer = residual_last;
   assign rsp_if.ready          = sample_ready;

   planar_predictor_decoder_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   residual_type pending_residuals[$];
   sample_type   expected_samples[$];

   int  error_count       = 0;
   int  sender_idle_pct   = 0;
   int  receiver_idle_pct = 0;
   bit  req_taken         = 1'b0;
   residual_type next_residual;
   sample_type   oldest_sample;

   // Predictor state and its copy of the registers
   logic [ROW_WIDTH_W-1:0] cfg_row_width = '0;
   logic [SIZE_W-1:0]      cfg_size      = SIZE_1B;
   logic [DATA_W-1:0]      prev_row [MAX_ROW_WIDTH];
   logic [DATA_W-1:0]      west_sample   = '0;
   logic [DATA_W-1:0]      north_hold    = '0;
   int unsigned            pos_col       = 0;
   bit                     pos_first_row = 1'b1;
   int unsigned            store_fill    = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic logic [DATA_W-1:0] lane_mask(input logic [SIZE_W-1:0] code);
      return {DATA_W{1'b1}} >> (DATA_W - (8 << code));
   endfunction

   // Rebuild one sample from its residual and advance the raster position
   function automatic sample_type reconstruct(input logic [DATA_W-1:0] residual,
                                              input logic last);
      logic [DATA_W-1:0] m;
      logic [DATA_W-1:0] north;
      logic [DATA_W-1:0] north_west;
      logic [DATA_W-1:0] west;
      logic [DATA_W-1:0] x;
      int unsigned       row_lim;
      bit                in_store;
      sample_type        r;
      m       = lane_mask(cfg_size);
      row_lim = (cfg_row_width > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : cfg_row_width;
      // a narrowed row ends before this transaction is taken
      if (row_lim != 0 && pos_col >= row_lim) begin
         pos_col       = 0;
         pos_first_row = 1'b0;
      end
      in_store   = pos_col < MAX_ROW_WIDTH;
      north      = (!pos_first_row && in_store) ? (prev_row[pos_col] & m) : '0;
      north_west = (pos_first_row || pos_col == 0) ? '0 : (north_hold & m);
      west       = (pos_col == 0) ? '0 : (west_sample & m);
      x          = ((residual & m) + west + north - north_west) & m;
      if (in_store) begin
         prev_row[pos_col] = x;
         if (pos_col + 1 > store_fill) store_fill = pos_col + 1;
      end
      north_hold  = north;
      west_sample = x;
      if (pos_col < MAX_ROW_WIDTH) pos_col++;
      if (row_lim != 0 && pos_col >= row_lim) begin
         pos_col       = 0;
         pos_first_row = 1'b0;
      end
      // end of buffer: return to the top-left corner
      if (last) begin
         west_sample   = '0;
         north_hold    = '0;
         pos_col       = 0;
         pos_first_row = 1'b1;
      end
      r.sample = x;
      r.last   = last;
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] pick_residual();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return {{(DATA_W-1){1'b0}}, 1'b1} << $urandom_range(DATA_W-1);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic push_residual(input logic [DATA_W-1:0] residual, input logic last);
      residual_type item;
      item.residual = residual;
      item.last     = last;
      item.drain    = 1'b0;
      pending_residuals.push_back(item);
   endtask

   // Queue random residuals; drain_at marks the item that waits for an empty pipe
   task automatic queue_residuals(input int count, input int last_pct, input bit end_last,
                                  input int drain_at);
      residual_type item;
      for (int i = 0; i < count; i++) begin
         item.residual = pick_residual();
         item.last     = ($urandom_range(99) < last_pct) || (end_last && i == count - 1);
         item.drain    = (i == drain_at);
         pending_residuals.push_back(item);
      end
   endtask

   // Hold until every queued transaction has come back, then let the pipe settle
   task automatic wait_idle();
      while (pending_residuals.size() != 0 || req_if.valid || expected_samples.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write one register, then read it back
   task automatic csr_update(input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== value)
         report_mismatch("register readback", DATA_W'(csr_prdata), DATA_W'(value));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic retune(input int unsigned width, input logic [SIZE_W-1:0] code);
      int unsigned reach;
      wait_idle();
      reach = (width == 0 || width > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : width;
      // keep rows below the first inside the part of the line store already written
      if (!pos_first_row && reach > store_fill) width = store_fill;
      csr_update(ADDR_ROW_WIDTH, width);
      csr_update(ADDR_ELT_SIZE, CSR_DATA_W'(code));
      @(posedge clock);
   endtask

   // Driver: present the next pending residual once the slot is free
   always @(negedge clock) begin
      if (reset) begin
         residual_valid <= 1'b0;
      end else if (!residual_valid || req_taken) begin
         if (pending_residuals.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
             !(pending_residuals[0].drain && expected_samples.size() != 0)) begin
            next_residual  = pending_residuals.pop_front();
            residual_valid <= 1'b1;
            residual_data  <= next_residual.residual;
            residual_last  <= next_residual.last;
         end else begin
            residual_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall at random
   always @(negedge clock) begin
      sample_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Monitor: check samples, track register writes, predict accepted transactions
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected sample", rsp_if.sample, '0);
            end else begin
               oldest_sample = expected_samples.pop_front();
               if (rsp_if.sample !== oldest_sample.sample)
                  report_mismatch("sample", rsp_if.sample, oldest_sample.sample);
               if (rsp_if.last_out !== oldest_sample.last)
                  report_mismatch("last_out", DATA_W'(rsp_if.last_out),
                                  DATA_W'(oldest_sample.last));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_ROW_WIDTH) cfg_row_width = csr_pwdata[ROW_WIDTH_W-1:0];
            else if (csr_paddr == ADDR_ELT_SIZE) cfg_size = csr_pwdata[SIZE_W-1:0];
         end
         if (req_if.valid && req_if.ready) begin
            req_taken = 1'b1;
            expected_samples.push_back(reconstruct(req_if.residual, req_if.last_in_buffer));
         end
      end
   end

   initial begin
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      sender_idle_pct   = 19;
      receiver_idle_pct = 66;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: single row, byte samples, upper residual bits ignored
      push_residual(64'hFFFF_FFFF_FFFF_FF80, 1'b0);
      push_residual(64'h0000_0000_0000_0001, 1'b0);
      push_residual(64'h0000_0000_0000_00FF, 1'b1);

      // One-sample rows read back the entry just written
      retune(1, SIZE_8B);
      push_residual('1, 1'b0);
      push_residual('1, 1'b0);
      push_residual(64'h1, 1'b0);
      push_residual(64'h8000_0000_0000_0000, 1'b0);
      push_residual('0, 1'b1);

      // Short last row
      retune(3, SIZE_1B);
      push_residual(64'hFF, 1'b0);
      push_residual(64'h01, 1'b0);
      push_residual(64'h80, 1'b0);
      push_residual(64'h7F, 1'b0);
      push_residual(64'hFF, 1'b0);
      push_residual(64'h00, 1'b0);
      push_residual(64'h55, 1'b1);

      // Row wider than the line store, left open
      retune(2047, SIZE_2B);
      push_residual(64'hFFFF, 1'b0);
      push_residual(64'h8000, 1'b0);
      push_residual(64'h0001, 1'b0);
      push_residual(64'h0000, 1'b0);
      push_residual(64'hFFFE, 1'b0);

      // Narrow the row mid-buffer so the open row ends at once
      retune(2, SIZE_4B);
      push_residual(64'hFFFF_FFFF, 1'b0);
      push_residual(64'h0, 1'b0);
      push_residual(64'h8000_0000, 1'b0);
      push_residual(64'h1, 1'b0);
      push_residual(64'h0, 1'b0);
      push_residual(64'h7FFF_FFFF, 1'b1);

      // Random part, receiver stalling often
      retune(4, SIZE_8B);
      queue_residuals(80, 5, 1'b0, 40);
      retune(1, SIZE_1B);
      queue_residuals(40, 10, 1'b1, -1);
      retune(0, SIZE_2B);
      queue_residuals(1030, 0, 1'b0, -1);

      // Sender idling often; the full-width row first ends the saturated one
      wait_idle();
      sender_idle_pct   = 66;
      receiver_idle_pct = 19;
      retune(MAX_ROW_WIDTH, SIZE_4B);
      queue_residuals(60, 0, 1'b1, 30);
      retune(7, SIZE_8B);
      queue_residuals(80, 4, 1'b0, -1);
      retune(2, SIZE_1B);
      queue_residuals(60, 8, 1'b0, -1);

      // No idling on either side
      wait_idle();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      retune(16, SIZE_2B);
      queue_residuals(60, 3, 1'b0, 20);
      retune(5, SIZE_8B);
      queue_residuals(40, 6, 1'b1, -1);

      wait_idle();
      if (error_count == 0) begin
         $display("planar_predictor_decoder_top_tb: done, clean");
      end else begin
         $display("planar_predictor_decoder_top_tb: done, errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #3_000_000;
      $display("planar_predictor_decoder_top_tb: done, errors");
      $finish;
   end

endmodule
